### hdl/ecdsa_p256_scalar_sign_assert.svh
// Assertion macros for the ECDSA P-256 scalar signing block.
`ifndef ECDSA_P256_SCALAR_SIGN_ASSERT_SVH
`define ECDSA_P256_SCALAR_SIGN_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define ESS_ASSERT_IMPLY(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define ESS_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);
`endif

### hdl/ess_pkg.sv
// Shared types and constants for the ECDSA P-256 scalar signing block.
package ess_pkg;
    localparam int unsigned OperandWords = 4;
    localparam int unsigned WordW = 64;
    localparam int unsigned OpW   = OperandWords * WordW;
    localparam logic [OpW-1:0] GroupOrder =
        256'hFFFFFFFF00000000FFFFFFFFFFFFFFFFBCE6FAADA7179E84F3B9CAC2FC632551;
    localparam logic [OpW-1:0] InvExp = GroupOrder - 256'd2;

    typedef enum logic [2:0] {
        REQ_KEY   = 3'd0,
        REQ_NONCE = 3'd1,
        REQ_DIG   = 3'd2,
        REQ_PX    = 3'd3,
        REQ_START = 3'd4
    } req_t;

    // Multiplier handshake
    typedef struct packed {
        logic start;
    } mul_ctl_t;
    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;
endpackage

### hdl/ecdsa_p256_scalar_sign.sv
// Top level of the ECDSA P-256 scalar signing block.
// Loads yield no output beat. A start that is rejected on the key, nonce or r
// offers its single beat in the output state, straight after the check state.
// A full signature runs 427 modular multiplications, then eight output beats,
// or a single rejection beat if s is zero; input reopens after the last beat
// once the block has passed through its wait state.
// aresetn (synchronous) clears control state and all four operand stores.
`include "ecdsa_p256_scalar_sign_assert.svh"
module ecdsa_p256_scalar_sign (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [1:0] word_index, [65:2] word_data
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] word_out, [66:64] word_index_out
    output logic        m_tuser,   // [0] status
    output logic        m_tlast
);
    localparam int unsigned W  = ess_pkg::OpW;
    localparam int unsigned WW = ess_pkg::WordW;
    localparam int unsigned IW = $clog2(ess_pkg::OperandWords);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_INVSQ = 9'b000000100,
        S_INVML = 9'b000001000,
        S_DR    = 9'b000010000,
        S_ADDH  = 9'b000100000,
        S_FIN   = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } st_t;

    st_t          st_reg;
    logic [WW-1:0] key_reg [ess_pkg::OperandWords];
    logic [WW-1:0] non_reg [ess_pkg::OperandWords];
    logic [WW-1:0] dig_reg [ess_pkg::OperandWords];
    logic [WW-1:0] px_reg  [ess_pkg::OperandWords];
    logic [W-1:0]  key_w, non_w, dig_w, px_w;
    logic [W-1:0]  r_reg, h_reg, kinv_reg, t_reg, e_reg;
    logic [8:0]    bit_reg;
    logic [2:0]    oidx_reg;
    logic          rej_reg;
    logic          mwait_reg;
    logic [W-1:0]  ma, mb, p;
    logic [W:0]    hs_w;
    logic          out_fire;
    ess_pkg::mul_ctl_t mctl;
    ess_pkg::mul_sts_t msts;

    logic [2:0]    s_req;
    logic [1:0]    s_idx;
    logic [63:0]   s_word;
    assign s_req  = s_tuser;
    assign s_idx  = s_tdata[1:0];
    assign s_word = s_tdata[65:2];

    always_comb begin
        for (int i = 0; i < ess_pkg::OperandWords; i++) begin
            key_w[i*WW +: WW] = key_reg[i];
            non_w[i*WW +: WW] = non_reg[i];
            dig_w[i*WW +: WW] = dig_reg[i];
            px_w[i*WW +: WW]  = px_reg[i];
        end
    end

    assign s_tready = (st_reg == S_IDLE);
    assign out_fire = m_tvalid && m_tready;

    // Store operand words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ess_pkg::OperandWords; i++) begin
                key_reg[i] <= '0;
                non_reg[i] <= '0;
                dig_reg[i] <= '0;
                px_reg[i]  <= '0;
            end
        end else if (s_tvalid && s_tready) begin
            case (s_req)
                ess_pkg::REQ_KEY:   key_reg[s_idx[IW-1:0]] <= s_word;
                ess_pkg::REQ_NONCE: non_reg[s_idx[IW-1:0]] <= s_word;
                ess_pkg::REQ_DIG:   dig_reg[s_idx[IW-1:0]] <= s_word;
                ess_pkg::REQ_PX:    px_reg[s_idx[IW-1:0]]  <= s_word;
                default: ;
            endcase
        end
    end

    // Multiplier operand select
    always_comb begin
        ma = kinv_reg;
        mb = kinv_reg;
        case (st_reg)
            S_INVSQ: begin ma = kinv_reg; mb = kinv_reg; end
            S_INVML: begin ma = non_w;    mb = kinv_reg; end
            S_DR:    begin ma = key_w;    mb = r_reg;    end
            S_FIN:   begin ma = kinv_reg; mb = t_reg;    end
            default: ;
        endcase
    end
    assign mctl.start = (st_reg == S_INVSQ || st_reg == S_INVML || st_reg == S_DR ||
                         st_reg == S_FIN) && !mwait_reg;

    ess_mulmod u_mul (
        .aclk(aclk), .aresetn(aresetn), .ctl(mctl),
        .a_in(ma), .b_in(mb), .sts(msts), .p_out(p)
    );

    always_comb begin
        hs_w = {1'b0, t_reg} + {1'b0, h_reg};
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            mwait_reg <= 1'b0;
        end else begin
            if (mctl.start) mwait_reg <= 1'b1;
            case (st_reg)
                S_IDLE: if (s_tvalid && s_req == ess_pkg::REQ_START) st_reg <= S_CHECK;
                S_CHECK: begin
                    h_reg    <= (dig_w >= ess_pkg::GroupOrder) ?
                                dig_w - ess_pkg::GroupOrder : dig_w;
                    r_reg    <= (px_w >= ess_pkg::GroupOrder) ?
                                px_w - ess_pkg::GroupOrder : px_w;
                    kinv_reg <= {{(W-1){1'b0}}, 1'b1};
                    e_reg    <= ess_pkg::InvExp;
                    bit_reg  <= 9'd256;
                    oidx_reg <= '0;
                    if (key_w == '0 || non_w == '0 || key_w >= ess_pkg::GroupOrder ||
                        px_w == '0 || px_w == ess_pkg::GroupOrder) begin
                        rej_reg <= 1'b1;
                        st_reg  <= S_OUT;
                    end else begin
                        rej_reg <= 1'b0;
                        st_reg  <= S_INVSQ;
                    end
                end
                S_INVSQ: if (mwait_reg && msts.done) begin
                    kinv_reg  <= p;
                    mwait_reg <= 1'b0;
                    if (e_reg[W-1]) st_reg <= S_INVML;
                    else begin
                        e_reg   <= {e_reg[W-2:0], 1'b0};
                        bit_reg <= bit_reg - 9'd1;
                        st_reg  <= (bit_reg == 9'd1) ? S_DR : S_INVSQ;
                    end
                end
                S_INVML: if (mwait_reg && msts.done) begin
                    kinv_reg  <= p;
                    mwait_reg <= 1'b0;
                    e_reg     <= {e_reg[W-2:0], 1'b0};
                    bit_reg   <= bit_reg - 9'd1;
                    st_reg    <= (bit_reg == 9'd1) ? S_DR : S_INVSQ;
                end
                S_DR: if (mwait_reg && msts.done) begin
                    t_reg     <= p;
                    mwait_reg <= 1'b0;
                    st_reg    <= S_ADDH;
                end
                S_ADDH: begin
                    t_reg  <= (hs_w >= {1'b0, ess_pkg::GroupOrder}) ?
                              W'(hs_w - {1'b0, ess_pkg::GroupOrder}) : hs_w[W-1:0];
                    st_reg <= S_FIN;
                end
                S_FIN: if (mwait_reg && msts.done) begin
                    t_reg     <= p;
                    mwait_reg <= 1'b0;
                    rej_reg   <= (p == '0);
                    st_reg    <= S_OUT;
                end
                S_OUT: if (out_fire) begin
                    if (m_tlast) st_reg <= S_WAIT;
                    oidx_reg <= oidx_reg + 3'd1;
                end
                S_WAIT: st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Drive result beats: r words then s words
    logic [WW-1:0] oword;
    always_comb begin
        if (oidx_reg[2]) oword = t_reg[oidx_reg[1:0]*WW +: WW];
        else             oword = r_reg[oidx_reg[1:0]*WW +: WW];
    end
    assign m_tvalid = (st_reg == S_OUT);
    assign m_tlast  = rej_reg || (oidx_reg == 3'd7);
    assign m_tuser  = rej_reg;
    assign m_tdata  = {5'd0, (rej_reg ? 3'd0 : oidx_reg),
                       (rej_reg ? {WW{1'b0}} : oword)};

    `ESS_ASSERT_IMPLY(a_rej_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast,
                      "rejection beat without last")
    `ESS_ASSERT_IMPLY(a_no_take, aclk, aresetn, m_tvalid, !s_tready,
                      "input taken during output")
    `ESS_ASSERT_NEXT(a_last_end, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid,
                     "beat after last")
endmodule

### hdl/ess_mulmod.sv
// Bit-serial modular multiplier: left-to-right double-and-add mod n.
module ess_mulmod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ess_pkg::mul_ctl_t            ctl,
    input  logic [ess_pkg::OpW-1:0]      a_in,
    input  logic [ess_pkg::OpW-1:0]      b_in,
    output ess_pkg::mul_sts_t            sts,
    output logic [ess_pkg::OpW-1:0]      p_out
);
    localparam int unsigned W = ess_pkg::OpW;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_RED  = 4'b0010,
        M_DBL  = 4'b0100,
        M_ADD  = 4'b1000
    } mst_t;

    mst_t         st_reg, st_next;
    logic [W-1:0] a_reg, b_reg, acc_reg;
    logic [8:0]   cnt_reg;
    logic         done_reg;
    logic [W:0]   sum_w, red_w;
    logic [W-1:0] addend;

    // Shared adder: acc plus acc or plus a, reduced once
    always_comb begin
        addend = (st_reg == M_DBL) ? acc_reg : a_reg;
        sum_w  = {1'b0, acc_reg} + {1'b0, addend};
        red_w  = sum_w - {1'b0, ess_pkg::GroupOrder};
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            M_IDLE: if (ctl.start) st_next = M_RED;
            M_RED:  st_next = M_DBL;
            M_DBL:  st_next = b_reg[W-1] ? M_ADD : ((cnt_reg == 9'd1) ? M_IDLE : M_DBL);
            M_ADD:  st_next = (cnt_reg == 9'd1) ? M_IDLE : M_DBL;
            default: st_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= M_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= (st_reg != M_IDLE) && (st_next == M_IDLE);
        end
    end

    // Datapath: one doubling or one addition per cycle
    always_ff @(posedge aclk) begin
        case (st_reg)
            M_IDLE: if (ctl.start) begin
                a_reg   <= a_in;
                b_reg   <= b_in;
                acc_reg <= '0;
                cnt_reg <= 9'd256;
            end
            M_RED: if (a_reg >= ess_pkg::GroupOrder) a_reg <= a_reg - ess_pkg::GroupOrder;
            M_DBL, M_ADD: begin
                acc_reg <= (sum_w >= {1'b0, ess_pkg::GroupOrder}) ? red_w[W-1:0]
                                                                  : sum_w[W-1:0];
                if ((st_reg == M_ADD) || !b_reg[W-1]) begin
                    b_reg   <= {b_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 9'd1;
                end
            end
            default: ;
        endcase
    end

    assign sts.busy = (st_reg != M_IDLE);
    assign sts.done = done_reg;
    assign p_out    = acc_reg;
endmodule

### tb/testbench.sv
// Self-checking testbench for the ECDSA P-256 signing scalar block.
`timescale 1ns / 100ps

module testbench;
    localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;
    localparam logic       STS_OK         = 1'b0;
    localparam logic       STS_REJECT     = 1'b1;
    localparam int         SIG_BEATS      = 8;
    localparam int         FULL_RUN_MAX   = 4;
    localparam int         HOLD_OFF_CYC   = 400;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        status;
        logic        last;
    } sig_beat_t;

    // Signing predictor and store of expected signature beats
    class sig_scoreboard;
        logic [255:0] key, k_nonce, dgst, px;
        sig_beat_t    pending_beats[$];
        int           errors;
        int           beats_seen;

        function new();
            key = '0; k_nonce = '0; dgst = '0; px = '0;
            errors = 0;
            beats_seen = 0;
        endfunction

        function logic [255:0] mod_mul(logic [255:0] a, logic [255:0] b);
            logic [511:0] prod;
            prod = 512'(a) * 512'(b);
            return 256'(prod % 512'(ess_pkg::GroupOrder));
        endfunction

        function logic [255:0] reduce_once(logic [255:0] a);
            return (a >= ess_pkg::GroupOrder) ? a - ess_pkg::GroupOrder : a;
        endfunction

        function bit runs_full();
            return !(key == '0 || k_nonce == '0 || key >= ess_pkg::GroupOrder ||
                     reduce_once(px) == '0);
        endfunction

        function void push_reject();
            sig_beat_t b;
            b.word = '0; b.index = '0; b.status = STS_REJECT; b.last = 1'b1;
            pending_beats.push_back(b);
        endfunction

        function void sign();
            logic [255:0] h, r, kinv, t, s, exp_inv;
            logic [256:0] sum;
            sig_beat_t    b;
            if (!runs_full()) begin
                push_reject();
                return;
            end
            h = reduce_once(dgst);
            r = reduce_once(px);
            // Fermat inverse of the nonce, most significant exponent bit first
            exp_inv = ess_pkg::GroupOrder - 256'd2;
            kinv = 256'd1;
            for (int i = 255; i >= 0; i--) begin
                kinv = mod_mul(kinv, kinv);
                if (exp_inv[i]) kinv = mod_mul(kinv, k_nonce);
            end
            t = mod_mul(key, r);
            sum = 257'(t) + 257'(h);
            if (sum >= 257'(ess_pkg::GroupOrder)) sum = sum - 257'(ess_pkg::GroupOrder);
            s = mod_mul(kinv, sum[255:0]);
            if (s == '0) begin
                push_reject();
                return;
            end
            for (int k = 0; k < SIG_BEATS; k++) begin
                b.word   = (k < 4) ? r[k*64 +: 64] : s[(k-4)*64 +: 64];
                b.index  = 3'(k);
                b.status = STS_OK;
                b.last   = (k == SIG_BEATS - 1);
                pending_beats.push_back(b);
            end
        endfunction

        function void note_input(logic [2:0] req, logic [1:0] idx, logic [63:0] data);
            case (req)
                ess_pkg::REQ_KEY:   key[idx*64 +: 64] = data;
                ess_pkg::REQ_NONCE: k_nonce[idx*64 +: 64] = data;
                ess_pkg::REQ_DIG:   dgst[idx*64 +: 64] = data;
                ess_pkg::REQ_PX:    px[idx*64 +: 64] = data;
                ess_pkg::REQ_START: sign();
                default: ;
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %0t: %s got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check(logic [63:0] word, logic [2:0] index, logic status, logic last);
            sig_beat_t b;
            beats_seen++;
            if (pending_beats.size() == 0) begin
                report("unexpected beat, word", word, '0);
                return;
            end
            b = pending_beats.pop_front();
            if (word !== b.word) report("word_out", word, b.word);
            if (index !== b.index) report("word_index_out", 64'(index), 64'(b.index));
            if (status !== b.status) report("status", 64'(status), 64'(b.status));
            if (last !== b.last) report("tlast", 64'(last), 64'(b.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sig_scoreboard sb = new();
    int items_sent = 0;
    int starts_sent = 0;
    int full_runs = 0;

    ecdsa_p256_scalar_sign u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    function int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task send_req(logic [2:0] req, logic [1:0] idx, logic [63:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, data, idx};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, idx, data);
        items_sent++;
        if (req == ess_pkg::REQ_START) begin
            starts_sent++;
        end
    endtask

    task load_operand(logic [2:0] req, logic [255:0] value);
        for (int i = 0; i < 4; i++) send_req(req, 2'(i), value[i*64 +: 64]);
    endtask

    task start_sign();
        if (sb.runs_full()) full_runs++;
        send_req(ess_pkg::REQ_START, 2'd0, '0);
    endtask

    function logic [63:0] rand_word();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Accept result beats with random stalls after an initial long hold-off
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        repeat (HOLD_OFF_CYC) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check(m_tdata[63:0], m_tdata[66:64], m_tuser, m_tlast);
        end
    end

    // Stop a hung run
    initial begin
        #120_000_000;
        $display("Timeout waiting for the block");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [2:0] req;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each reject reason, ignored codes, reductions, s of zero
        start_sign();
        send_req(ess_pkg::REQ_KEY, 2'd0, 64'd1);
        start_sign();
        send_req(ess_pkg::REQ_NONCE, 2'd0, 64'd5);
        start_sign();
        load_operand(ess_pkg::REQ_KEY, ess_pkg::GroupOrder);
        start_sign();
        send_req(ess_pkg::REQ_KEY, 2'd3, 64'd0);
        load_operand(ess_pkg::REQ_PX, ess_pkg::GroupOrder);
        start_sign();
        for (int c = REQ_RSVD_FIRST; c <= REQ_RSVD_LAST; c++) begin
            send_req(3'(c), 2'(c), '1);
        end
        send_req(ess_pkg::REQ_PX, 2'd0, ess_pkg::GroupOrder[63:0] + 64'd7);
        send_req(ess_pkg::REQ_DIG, 2'd3, '1);
        send_req(ess_pkg::REQ_NONCE, 2'd3, '1);
        start_sign();
        load_operand(ess_pkg::REQ_NONCE, ess_pkg::GroupOrder);
        start_sign();

        // Random: short load sequences ending in a start, with some noise
        while (items_sent < 100) begin
            if ($urandom_range(0, 9) == 0) begin
                req = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
            end else begin
                req = 3'($urandom_range(ess_pkg::REQ_KEY, ess_pkg::REQ_PX));
            end
            send_req(req, 2'($urandom_range(0, 3)), rand_word());
            if ($urandom_range(0, 2) == 0) begin
                // Keep the number of long signing runs bounded
                if (sb.runs_full() && full_runs >= FULL_RUN_MAX) begin
                    send_req(ess_pkg::REQ_KEY, 2'd3, '1);
                end
                start_sign();
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time for any stray beat
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Sent %0d request beats, %0d starts, %0d full signing runs",
                 items_sent, starts_sent, full_runs);
        $display("Checked %0d result beats, %0d mismatches", sb.beats_seen, sb.errors);
        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/ess_pkg.sv
hdl/ess_mulmod.sv
hdl/ecdsa_p256_scalar_sign.sv
tb/testbench.sv
